### src/imt_pkg.sv
// ----------------------------------------------------------------------------
// imt_pkg
// Shared constants, codes and controller/datapath interface types for the
// innovation match table.
// ----------------------------------------------------------------------------
package imt_pkg;

	localparam int TABLE_DEPTH  = 64;
	localparam int ID_BITS      = 31;
	localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);
	localparam int CMD_BITS     = 3;
	localparam int STATUS_BITS  = 3;
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_LOOKUP     = 3'd0,
		CMD_LIST       = 3'd1,
		CMD_ADD_LINK   = 3'd2,
		CMD_ADD_NEURON = 3'd3,
		CMD_FLUSH      = 3'd4,
		CMD_RESTART    = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_INVALID   = 3'd2,
		ST_FULL      = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_START_INNOVATION = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_NEURON     = 2'd1;

	typedef struct packed {
		logic [ID_BITS-1:0] source;
		logic [ID_BITS-1:0] target;
		logic               kind;
		logic [ID_BITS-1:0] innovation;
		logic [ID_BITS-1:0] neuron;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic cap;
		logic latch;
		logic append;
		logic clear;
		logic reload;
		logic rd_en;
		logic step;
		logic push_fin;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_BITS-1:0] cmd;
		logic                pre_ok;
		logic                count_zero;
		logic                last_entry;
		logic                match_list;
		logic                pend_valid;
		logic                out_free;
	} sts_t;

endpackage

### src/innovation_match_table_core.sv
// ----------------------------------------------------------------------------
// innovation_match_table_core
// Innovation record table with lookup, list, add, flush and restart commands.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_stall) carries one command beat; it is taken
//   when in_valid is high and in_stall low. in_stall stays high from the
//   accepted beat until the command's final result is loaded.
//   output channel (out_valid/out_stall) carries result beats from an output
//   register; last_of_run marks the final beat of a command.
//   cfg_valid/cfg_ready writes start_innovation (index 0) or start_neuron
//   (index 1); cfg_ready is always high, other indexes are ignored.
// Sequence:
//   add, flush, restart and rejected commands: decode, then the result is
//   loaded; the next command is accepted only after that load.
//   lookup and list scan the stored records one entry at a time (RAM read
//   then compare), then load the final result.
//   a list with many matches also waits on the output register.
// Reset: table empty, both id counters and start registers at 1.
// Stall: a stalled result beat holds; a list scan pauses on the next match
// until the beat is taken.
// ----------------------------------------------------------------------------
module innovation_match_table_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [imt_pkg::CMD_BITS-1:0]      cmd,
	input  logic [imt_pkg::ID_BITS-1:0]       source_id,
	input  logic [imt_pkg::ID_BITS-1:0]       target_id,
	input  logic                              kind,
	input  logic                              neuron_is_hidden,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [imt_pkg::STATUS_BITS-1:0]   status,
	output logic [imt_pkg::ID_BITS-1:0]       first_innovation,
	output logic [imt_pkg::ID_BITS-1:0]       last_innovation,
	output logic [imt_pkg::ID_BITS-1:0]       first_neuron,
	output logic [imt_pkg::ID_BITS-1:0]       last_neuron,
	output logic [imt_pkg::IDX_BITS-1:0]      match_index,
	output logic                              last_of_run,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [imt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [imt_pkg::ID_BITS-1:0]       cfg_data
);

	import imt_pkg::*;

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	imt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	imt_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.source_id        (source_id),
		.target_id        (target_id),
		.kind             (kind),
		.neuron_is_hidden (neuron_is_hidden),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.ctl              (ctl),
		.sts              (sts),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.status           (status),
		.first_innovation (first_innovation),
		.last_innovation  (last_innovation),
		.first_neuron     (first_neuron),
		.last_neuron      (last_neuron),
		.match_index      (match_index),
		.last_of_run      (last_of_run)
	);

endmodule

### src/imt_ram.sv
// ----------------------------------------------------------------------------
// imt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module imt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### src/imt_datapath.sv
// ----------------------------------------------------------------------------
// imt_datapath
// Command capture, record store, id counters, scan accumulators and the
// output register of the innovation match table.
// ----------------------------------------------------------------------------
module imt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [imt_pkg::CMD_BITS-1:0]      cmd,
	input  logic [imt_pkg::ID_BITS-1:0]       source_id,
	input  logic [imt_pkg::ID_BITS-1:0]       target_id,
	input  logic                              kind,
	input  logic                              neuron_is_hidden,
	input  logic                              cfg_valid,
	input  logic [imt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [imt_pkg::ID_BITS-1:0]       cfg_data,
	input  imt_pkg::ctl_t                     ctl,
	output imt_pkg::sts_t                     sts,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [imt_pkg::STATUS_BITS-1:0]   status,
	output logic [imt_pkg::ID_BITS-1:0]       first_innovation,
	output logic [imt_pkg::ID_BITS-1:0]       last_innovation,
	output logic [imt_pkg::ID_BITS-1:0]       first_neuron,
	output logic [imt_pkg::ID_BITS-1:0]       last_neuron,
	output logic [imt_pkg::IDX_BITS-1:0]      match_index,
	output logic                              last_of_run
);

	import imt_pkg::*;

	// captured command
	logic [CMD_BITS-1:0] cmd_q;
	logic [ID_BITS-1:0]  src_q;
	logic [ID_BITS-1:0]  dst_q;
	logic                kind_q;
	logic                hidden_q;

	// table and counter state
	logic [CNT_BITS-1:0] count_q;
	logic [ID_BITS-1:0]  next_innov_q;
	logic [ID_BITS-1:0]  next_neuron_q;
	logic [ID_BITS-1:0]  start_innov_q;
	logic [ID_BITS-1:0]  start_neuron_q;

	// scan state
	logic [IDX_BITS-1:0] idx_q;
	status_t             err_q;
	logic                found_q;
	logic                nfound_q;
	logic [ID_BITS-1:0]  fi_q;
	logic [ID_BITS-1:0]  li_q;
	logic [ID_BITS-1:0]  fn_q;
	logic [ID_BITS-1:0]  ln_q;
	logic                pend_valid_q;
	logic [ID_BITS-1:0]  pend_innov_q;
	logic [ID_BITS-1:0]  pend_neuron_q;
	logic [IDX_BITS-1:0] pend_idx_q;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [ID_BITS-1:0]  out_fi_q;
	logic [ID_BITS-1:0]  out_li_q;
	logic [ID_BITS-1:0]  out_fn_q;
	logic [ID_BITS-1:0]  out_ln_q;
	logic [IDX_BITS-1:0] out_idx_q;
	logic                out_last_q;

	entry_t              wr_entry;
	entry_t              rd_entry;
	logic                is_neuron;
	logic                bad_ends;
	logic                full;
	status_t             pre_status;
	logic                ends_match;
	logic                match_list;
	logic                out_free;
	logic                load_pend;

	status_t             fin_status;
	logic [ID_BITS-1:0]  fin_fi;
	logic [ID_BITS-1:0]  fin_li;
	logic [ID_BITS-1:0]  fin_fn;
	logic [ID_BITS-1:0]  fin_ln;
	logic [IDX_BITS-1:0] fin_idx;

	assign is_neuron = (cmd_q == CMD_ADD_NEURON);
	assign bad_ends  = (src_q == '0) || (dst_q == '0);
	assign full      = (count_q == CNT_BITS'(TABLE_DEPTH));

	always_comb begin
		case (cmd_t'(cmd_q))
			CMD_LOOKUP, CMD_LIST: begin
				pre_status = bad_ends ? ST_INVALID : ST_OK;
			end
			CMD_ADD_LINK: begin
				if (bad_ends) begin
					pre_status = ST_INVALID;
				end else if (full) begin
					pre_status = ST_FULL;
				end else if (next_innov_q == '0) begin
					pre_status = ST_OVERFLOW;
				end else begin
					pre_status = ST_OK;
				end
			end
			CMD_ADD_NEURON: begin
				if (bad_ends || !hidden_q) begin
					pre_status = ST_INVALID;
				end else if (full) begin
					pre_status = ST_FULL;
				end else if ((next_innov_q == '0) || (next_neuron_q == '0)) begin
					pre_status = ST_OVERFLOW;
				end else begin
					pre_status = ST_OK;
				end
			end
			CMD_FLUSH, CMD_RESTART: begin
				pre_status = ST_OK;
			end
			default: begin
				pre_status = ST_INVALID;
			end
		endcase
	end

	// record store
	assign wr_entry.source     = src_q;
	assign wr_entry.target     = dst_q;
	assign wr_entry.kind       = is_neuron;
	assign wr_entry.innovation = next_innov_q;
	assign wr_entry.neuron     = is_neuron ? next_neuron_q : '0;

	imt_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ctl.append),
		.wr_addr (count_q[IDX_BITS-1:0]),
		.wr_data (wr_entry),
		.rd_en   (ctl.rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_entry)
	);

	assign ends_match = (rd_entry.source == src_q) && (rd_entry.target == dst_q);
	assign match_list = ends_match && (rd_entry.kind == kind_q);

	assign out_free  = !out_valid_q || !out_stall;
	// a new list match pushes the previous one out as a non-final beat
	assign load_pend = ctl.step && (cmd_q == CMD_LIST) && match_list && pend_valid_q;

	always_comb begin
		fin_status = ST_OK;
		fin_fi     = '0;
		fin_li     = '0;
		fin_fn     = '0;
		fin_ln     = '0;
		fin_idx    = '0;
		if (err_q != ST_OK) begin
			fin_status = err_q;
		end else begin
			case (cmd_t'(cmd_q))
				CMD_LOOKUP: begin
					fin_status = found_q ? ST_OK : ST_NOT_FOUND;
					fin_fi     = fi_q;
					fin_li     = li_q;
					fin_fn     = fn_q;
					fin_ln     = ln_q;
				end
				CMD_LIST: begin
					if (pend_valid_q) begin
						fin_fi  = pend_innov_q;
						fin_fn  = pend_neuron_q;
						fin_idx = pend_idx_q;
					end else begin
						fin_status = ST_NOT_FOUND;
					end
				end
				CMD_ADD_LINK, CMD_ADD_NEURON: begin
					fin_fi = fi_q;
					fin_fn = fn_q;
				end
				default: begin
					fin_status = ST_OK;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			next_innov_q   <= ID_BITS'(1);
			next_neuron_q  <= ID_BITS'(1);
			start_innov_q  <= ID_BITS'(1);
			start_neuron_q <= ID_BITS'(1);
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_START_INNOVATION: start_innov_q  <= cfg_data;
					REG_START_NEURON:     start_neuron_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.append) begin
				count_q      <= count_q + CNT_BITS'(1);
				next_innov_q <= next_innov_q + ID_BITS'(1);
				if (is_neuron) begin
					next_neuron_q <= next_neuron_q + ID_BITS'(1);
				end
			end
			if (ctl.clear || ctl.reload) begin
				count_q <= '0;
			end
			if (ctl.reload) begin
				next_innov_q  <= start_innov_q;
				next_neuron_q <= start_neuron_q;
			end
			if (ctl.cap) begin
				pend_valid_q <= 1'b0;
			end else if (ctl.step && (cmd_q == CMD_LIST) && match_list) begin
				pend_valid_q <= 1'b1;
			end
			if (load_pend || ctl.push_fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q    <= cmd;
			src_q    <= source_id;
			dst_q    <= target_id;
			kind_q   <= kind;
			hidden_q <= neuron_is_hidden;
			idx_q    <= '0;
			found_q  <= 1'b0;
			nfound_q <= 1'b0;
			fi_q     <= '0;
			li_q     <= '0;
			fn_q     <= '0;
			ln_q     <= '0;
		end
		if (ctl.latch) begin
			err_q <= pre_status;
		end
		if (ctl.append) begin
			fi_q <= next_innov_q;
			fn_q <= is_neuron ? next_neuron_q : '0;
		end
		if (ctl.step) begin
			idx_q <= idx_q + IDX_BITS'(1);
			if (cmd_q == CMD_LOOKUP) begin
				if (match_list) begin
					if (!found_q) begin
						fi_q <= rd_entry.innovation;
					end
					li_q    <= rd_entry.innovation;
					found_q <= 1'b1;
				end
				if (ends_match && rd_entry.kind) begin
					if (!nfound_q) begin
						fn_q <= rd_entry.neuron;
					end
					ln_q     <= rd_entry.neuron;
					nfound_q <= 1'b1;
				end
			end
			if ((cmd_q == CMD_LIST) && match_list) begin
				pend_innov_q  <= rd_entry.innovation;
				pend_neuron_q <= rd_entry.neuron;
				pend_idx_q    <= idx_q;
			end
		end
		if (load_pend) begin
			out_status_q <= ST_OK;
			out_fi_q     <= pend_innov_q;
			out_li_q     <= '0;
			out_fn_q     <= pend_neuron_q;
			out_ln_q     <= '0;
			out_idx_q    <= pend_idx_q;
			out_last_q   <= 1'b0;
		end else if (ctl.push_fin) begin
			out_status_q <= fin_status;
			out_fi_q     <= fin_fi;
			out_li_q     <= fin_li;
			out_fn_q     <= fin_fn;
			out_ln_q     <= fin_ln;
			out_idx_q    <= fin_idx;
			out_last_q   <= 1'b1;
		end
	end

	assign sts.cmd        = cmd_q;
	assign sts.pre_ok     = (pre_status == ST_OK);
	assign sts.count_zero = (count_q == '0);
	assign sts.last_entry = ((CNT_BITS'(idx_q) + CNT_BITS'(1)) == count_q);
	assign sts.match_list = match_list;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign first_innovation = out_fi_q;
	assign last_innovation  = out_li_q;
	assign first_neuron     = out_fn_q;
	assign last_neuron      = out_ln_q;
	assign match_index      = out_idx_q;
	assign last_of_run      = out_last_q;

endmodule

### src/imt_ctrl.sv
// ----------------------------------------------------------------------------
// imt_ctrl
// Command sequencer: decode, table scan one entry at a time, result push.
// ----------------------------------------------------------------------------
module imt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  imt_pkg::sts_t sts,
	output imt_pkg::ctl_t ctl
);

	import imt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_CMP,
		S_FIN
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   cmp_hold;

	// a list match must wait while the previous match cannot leave
	assign cmp_hold = (sts.cmd == CMD_LIST) && sts.match_list && sts.pend_valid && !sts.out_free;

	always_comb begin
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				ctl.cap = in_valid;
			end
			S_DECODE: begin
				ctl.latch = 1'b1;
				if (sts.pre_ok) begin
					case (cmd_t'(sts.cmd))
						CMD_ADD_LINK, CMD_ADD_NEURON: ctl.append = 1'b1;
						CMD_FLUSH:                    ctl.clear  = 1'b1;
						CMD_RESTART:                  ctl.reload = 1'b1;
						default: ;
					endcase
				end
			end
			S_READ: begin
				ctl.rd_en = 1'b1;
			end
			S_CMP: begin
				ctl.step = !cmp_hold;
			end
			S_FIN: begin
				ctl.push_fin = sts.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
						busy_q  <= 1'b1;
					end
				end
				S_DECODE: begin
					if (sts.pre_ok && !sts.count_zero &&
					    ((sts.cmd == CMD_LOOKUP) || (sts.cmd == CMD_LIST))) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!cmp_hold) begin
						state_q <= sts.last_entry ? S_FIN : S_READ;
					end
				end
				S_FIN: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign in_stall = busy_q;

endmodule

### src/imt_checker.sv
// ----------------------------------------------------------------------------
// imt_checker
// Port-level assertions for the innovation match table, bound to the top.
// ----------------------------------------------------------------------------
module imt_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [imt_pkg::STATUS_BITS-1:0]   status,
	input logic [imt_pkg::ID_BITS-1:0]       first_innovation,
	input logic [imt_pkg::ID_BITS-1:0]       last_innovation,
	input logic [imt_pkg::ID_BITS-1:0]       first_neuron,
	input logic [imt_pkg::ID_BITS-1:0]       last_neuron,
	input logic [imt_pkg::IDX_BITS-1:0]      match_index,
	input logic                              last_of_run
);

	import imt_pkg::*;

	// one command at a time: an accepted beat blocks the input channel
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after a command beat");

	// only list matches may come before the final beat, always with ok status
	a_mid_run_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_run) |-> (status == ST_OK))
		else $error("non-final result beat with error status");

	// an error or not-found result ends its run
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> last_of_run)
		else $error("error result beat not marked last");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) &&
		$stable(first_innovation) && $stable(last_innovation) &&
		$stable(first_neuron) && $stable(last_neuron) &&
		$stable(match_index) && $stable(last_of_run)))
		else $error("stalled result beat changed");

endmodule

bind innovation_match_table_core imt_checker u_imt_checker (.*);

### sim/innovation_match_table_core_test.sv
// ----------------------------------------------------------------------------
// innovation_match_table_core_test
// Self-checking bench for the innovation match table: a queue-fed driver
// offers commands with random gaps, a monitor predicts every result beat from
// its own copy of the table and counters and compares each beat in order.
// ----------------------------------------------------------------------------
module innovation_match_table_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import imt_pkg::*;

	localparam logic [ID_BITS-1:0]      ID_MAX       = '1;
	localparam logic [CMD_BITS-1:0]     CMD_UNUSED_A = 3'd6;
	localparam logic [CMD_BITS-1:0]     CMD_UNUSED_B = 3'd7;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_B = 2'd3;
	localparam int                      CYCLE_LIMIT  = 10000000;

	typedef struct packed {
		logic [CMD_BITS-1:0] op;
		logic [ID_BITS-1:0]  src;
		logic [ID_BITS-1:0]  dst;
		logic                kind;
		logic                hidden;
	} command_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] st;
		logic [ID_BITS-1:0]     inn_first;
		logic [ID_BITS-1:0]     inn_last;
		logic [ID_BITS-1:0]     neu_first;
		logic [ID_BITS-1:0]     neu_last;
		logic [IDX_BITS-1:0]    idx;
		logic                   tail;
	} reply_t;

	logic                    clk;
	logic                    arst_n           = 1'b0;
	logic                    in_valid         = 1'b0;
	logic                    in_stall;
	logic [CMD_BITS-1:0]     cmd              = '0;
	logic [ID_BITS-1:0]      source_id        = '0;
	logic [ID_BITS-1:0]      target_id        = '0;
	logic                    kind             = 1'b0;
	logic                    neuron_is_hidden = 1'b0;
	logic                    out_valid;
	logic                    out_stall        = 1'b0;
	logic [STATUS_BITS-1:0]  status;
	logic [ID_BITS-1:0]      first_innovation;
	logic [ID_BITS-1:0]      last_innovation;
	logic [ID_BITS-1:0]      first_neuron;
	logic [ID_BITS-1:0]      last_neuron;
	logic [IDX_BITS-1:0]     match_index;
	logic                    last_of_run;
	logic                    cfg_valid        = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index        = '0;
	logic [ID_BITS-1:0]      cfg_data         = '0;

	// predicted table contents and counters
	logic [ID_BITS-1:0] rec_source [TABLE_DEPTH];
	logic [ID_BITS-1:0] rec_target [TABLE_DEPTH];
	logic               rec_kind   [TABLE_DEPTH];
	logic [ID_BITS-1:0] rec_innov  [TABLE_DEPTH];
	logic [ID_BITS-1:0] rec_neuron [TABLE_DEPTH];
	int                 rec_count        = 0;
	logic [ID_BITS-1:0] next_innov_id    = 1;
	logic [ID_BITS-1:0] next_neuron_id   = 1;
	logic [ID_BITS-1:0] start_innov_reg  = 1;
	logic [ID_BITS-1:0] start_neuron_reg = 1;

	command_t command_q [$];
	reply_t   table_replies [$];

	bit offering    = 1'b0;
	bit cmd_taken   = 1'b0;
	int send_gap    = 0;
	int send_calm   = 0;
	int recv_gap    = 0;
	int recv_calm   = 0;
	int hold_left   = 0;
	int hold_request = 0;
	int fault_count = 0;
	int cycle_count = 0;

	innovation_match_table_core dut (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int pick_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(99);
		if (roll < 4) begin
			calm = $urandom_range(40, 15);
			return 0;
		end
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// works out the result beats of one accepted command and updates the table
	task automatic apply_command(input command_t c);
		reply_t r;
		bit     bad_ends;
		bit     found;
		bit     nfound;
		bit     neu;
		int     hits;
		int     k;
		r = '0;
		r.tail = 1'b1;
		bad_ends = (c.src == 0) || (c.dst == 0);
		case (c.op)
			CMD_LOOKUP: begin
				found = 0;
				nfound = 0;
				if (bad_ends)
					r.st = ST_INVALID;
				else begin
					for (int i = 0; i < rec_count; i++) begin
						if (rec_source[i] == c.src && rec_target[i] == c.dst) begin
							if (rec_kind[i] == c.kind) begin
								if (!found)
									r.inn_first = rec_innov[i];
								r.inn_last = rec_innov[i];
								found = 1;
							end
							if (rec_kind[i]) begin
								if (!nfound)
									r.neu_first = rec_neuron[i];
								r.neu_last = rec_neuron[i];
								nfound = 1;
							end
						end
					end
					r.st = found ? ST_OK : ST_NOT_FOUND;
				end
				table_replies.push_back(r);
			end
			CMD_LIST: begin
				hits = 0;
				if (!bad_ends)
					for (int i = 0; i < rec_count; i++)
						if (rec_source[i] == c.src && rec_target[i] == c.dst &&
						    rec_kind[i] == c.kind)
							hits++;
				if (bad_ends || hits == 0) begin
					r.st = bad_ends ? ST_INVALID : ST_NOT_FOUND;
					table_replies.push_back(r);
				end else begin
					k = 0;
					for (int i = 0; i < rec_count; i++) begin
						if (rec_source[i] == c.src && rec_target[i] == c.dst &&
						    rec_kind[i] == c.kind) begin
							k++;
							r = '0;
							r.st = ST_OK;
							r.inn_first = rec_innov[i];
							r.neu_first = rec_neuron[i];
							r.idx = IDX_BITS'(i);
							r.tail = (k == hits);
							table_replies.push_back(r);
						end
					end
				end
			end
			CMD_ADD_LINK, CMD_ADD_NEURON: begin
				neu = (c.op == CMD_ADD_NEURON);
				if (bad_ends || (neu && !c.hidden))
					r.st = ST_INVALID;
				else if (rec_count >= TABLE_DEPTH)
					r.st = ST_FULL;
				else if (next_innov_id == 0 || (neu && next_neuron_id == 0))
					r.st = ST_OVERFLOW;
				else begin
					r.st = ST_OK;
					r.inn_first = next_innov_id;
					next_innov_id++;
					if (neu) begin
						r.neu_first = next_neuron_id;
						next_neuron_id++;
					end
					rec_source[rec_count] = c.src;
					rec_target[rec_count] = c.dst;
					rec_kind[rec_count]   = neu;
					rec_innov[rec_count]  = r.inn_first;
					rec_neuron[rec_count] = r.neu_first;
					rec_count++;
				end
				table_replies.push_back(r);
			end
			CMD_FLUSH: begin
				rec_count = 0;
				r.st = ST_OK;
				table_replies.push_back(r);
			end
			CMD_RESTART: begin
				rec_count = 0;
				next_innov_id = start_innov_reg;
				next_neuron_id = start_neuron_reg;
				r.st = ST_OK;
				table_replies.push_back(r);
			end
			default: begin
				r.st = ST_INVALID;
				table_replies.push_back(r);
			end
		endcase
	endtask

	// command driver
	always @(negedge clk) begin
		command_t c;
		if (cmd_taken) begin
			cmd_taken = 1'b0;
			offering = 1'b0;
		end
		if (!offering && arst_n) begin
			if (send_gap > 0)
				send_gap--;
			else if (command_q.size() > 0) begin
				c = command_q.pop_front();
				cmd <= c.op;
				source_id <= c.src;
				target_id <= c.dst;
				kind <= c.kind;
				neuron_is_hidden <= c.hidden;
				offering = 1'b1;
				send_gap = pick_gap(send_calm);
			end
		end
		in_valid <= offering;
	end

	// result receiver back-pressure, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			recv_gap = pick_gap(recv_calm);
		end
	end

	// monitor: check result beats first, then predict for an accepted command
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{status, first_innovation, last_innovation, first_neuron,
				        last_neuron, match_index, last_of_run};
				if (table_replies.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected result beat: st=%0d fi=%0d li=%0d fn=%0d ln=%0d idx=%0d tail=%0d",
						         got.st, got.inn_first, got.inn_last, got.neu_first,
						         got.neu_last, got.idx, got.tail);
				end else begin
					want = table_replies.pop_front();
					if (got !== want) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("result mismatch at cycle %0d", cycle_count);
							$display("  expected st=%0d fi=%0d li=%0d fn=%0d ln=%0d idx=%0d tail=%0d",
							         want.st, want.inn_first, want.inn_last, want.neu_first,
							         want.neu_last, want.idx, want.tail);
							$display("  actual   st=%0d fi=%0d li=%0d fn=%0d ln=%0d idx=%0d tail=%0d",
							         got.st, got.inn_first, got.inn_last, got.neu_first,
							         got.neu_last, got.idx, got.tail);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				cmd_taken = 1'b1;
				apply_command('{cmd, source_id, target_id, kind, neuron_is_hidden});
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_cmd(input logic [CMD_BITS-1:0] op, input logic [ID_BITS-1:0] src,
	                        input logic [ID_BITS-1:0] dst, input logic k, input logic h);
		command_q.push_back('{op, src, dst, k, h});
	endtask

	// wait until the block has nothing left in flight
	task automatic settle();
		while (command_q.size() != 0 || offering || table_replies.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [ID_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_START_INNOVATION)
			start_innov_reg = val;
		else if (idx == REG_START_NEURON)
			start_neuron_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed traffic on a few recurring endpoint pairs
	task automatic random_phase(input int count);
		logic [ID_BITS-1:0] pool_src [6];
		logic [ID_BITS-1:0] pool_dst [6];
		command_t           c;
		int                 roll;
		int                 p;
		for (int i = 0; i < 6; i++) begin
			pool_src[i] = ID_BITS'($urandom_range(ID_MAX, 1));
			pool_dst[i] = ID_BITS'($urandom_range(ID_MAX, 1));
		end
		pool_src[2] = 1;
		pool_dst[3] = ID_MAX;
		// reversed endpoints must not match
		pool_src[1] = pool_dst[0];
		pool_dst[1] = pool_src[0];
		repeat (count) begin
			roll = $urandom_range(99);
			p = $urandom_range(5);
			c.src = pool_src[p];
			c.dst = pool_dst[p];
			c.kind = 1'($urandom_range(1));
			c.hidden = 1'($urandom_range(1));
			if ($urandom_range(9) == 0) begin
				c.src = ID_BITS'($urandom_range(ID_MAX, 1));
				c.dst = ID_BITS'($urandom_range(ID_MAX, 1));
			end
			if (roll < 25)
				c.op = CMD_LOOKUP;
			else if (roll < 40)
				c.op = CMD_LIST;
			else if (roll < 62)
				c.op = CMD_ADD_LINK;
			else if (roll < 84) begin
				c.op = CMD_ADD_NEURON;
				c.hidden = 1'b1;
			end else if (roll < 87)
				c.op = CMD_FLUSH;
			else if (roll < 89)
				c.op = CMD_RESTART;
			else begin
				case ($urandom_range(3))
					0: begin
						c.op = CMD_BITS'($urandom_range(7));
						c.src = ID_BITS'($urandom());
						c.dst = ID_BITS'($urandom());
					end
					1: begin
						c.op = $urandom_range(1) ? CMD_LOOKUP : CMD_ADD_LINK;
						if ($urandom_range(1))
							c.op = $urandom_range(1) ? CMD_LIST : CMD_ADD_NEURON;
						if ($urandom_range(1))
							c.src = '0;
						else
							c.dst = '0;
					end
					2: begin
						c.op = CMD_ADD_NEURON;
						c.hidden = 1'b0;
					end
					default: c.op = $urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B;
				endcase
			end
			command_q.push_back(c);
		end
	endtask

	initial begin
		logic [ID_BITS-1:0] fill_src;
		logic [ID_BITS-1:0] fill_dst;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, basic adds, rejects, lookups and lists
		push_cmd(CMD_LOOKUP, 5, 9, 0, 0);
		push_cmd(CMD_LIST, 5, 9, 0, 1);
		push_cmd(CMD_ADD_LINK, 1, ID_MAX, 1, 0);
		push_cmd(CMD_ADD_NEURON, 1, ID_MAX, 0, 1);
		push_cmd(CMD_ADD_LINK, 1, ID_MAX, 0, 1);
		push_cmd(CMD_ADD_NEURON, ID_MAX, 1, 1, 0);
		push_cmd(CMD_ADD_LINK, 0, ID_MAX, 0, 1);
		push_cmd(CMD_ADD_NEURON, 1, 0, 1, 1);
		push_cmd(CMD_LOOKUP, 0, 0, 1, 1);
		push_cmd(CMD_LIST, ID_MAX, 0, 0, 0);
		push_cmd(CMD_LOOKUP, 1, ID_MAX, 0, 0);
		push_cmd(CMD_LOOKUP, 1, ID_MAX, 1, 0);
		push_cmd(CMD_LIST, 1, ID_MAX, 0, 0);
		push_cmd(CMD_LIST, 1, ID_MAX, 1, 1);
		push_cmd(CMD_UNUSED_A, ID_MAX, ID_MAX, 1, 1);
		push_cmd(CMD_UNUSED_B, 1, 1, 0, 0);
		push_cmd(CMD_FLUSH, 0, 0, 0, 0);
		push_cmd(CMD_LOOKUP, 1, ID_MAX, 0, 0);
		settle();

		// innovation counter wraps after the largest id
		write_reg(REG_START_INNOVATION, ID_MAX);
		write_reg(REG_START_NEURON, ID_MAX);
		push_cmd(CMD_RESTART, 0, 0, 0, 0);
		push_cmd(CMD_ADD_NEURON, ID_MAX, ID_MAX, 1, 1);
		push_cmd(CMD_ADD_LINK, ID_MAX, ID_MAX, 0, 1);
		settle();

		// restart loading zero exhausts the counter
		write_reg(REG_START_INNOVATION, 0);
		write_reg(REG_START_NEURON, 7);
		write_reg(REG_UNUSED_A, ID_BITS'($urandom()));
		write_reg(REG_UNUSED_B, ID_BITS'($urandom()));
		push_cmd(CMD_RESTART, ID_MAX, ID_MAX, 1, 1);
		push_cmd(CMD_ADD_LINK, 3, 4, 0, 0);
		settle();

		// only the neuron counter runs out
		write_reg(REG_START_INNOVATION, 9);
		write_reg(REG_START_NEURON, ID_MAX);
		push_cmd(CMD_RESTART, 0, 0, 0, 0);
		push_cmd(CMD_ADD_NEURON, 2, 3, 0, 1);
		push_cmd(CMD_ADD_NEURON, 2, 3, 0, 1);
		push_cmd(CMD_ADD_LINK, 2, 3, 0, 1);
		settle();

		// fill the table on one endpoint pair, then a long list under hold-off
		write_reg(REG_START_INNOVATION, ID_BITS'($urandom_range(1 << 20, 1)));
		write_reg(REG_START_NEURON, ID_BITS'($urandom_range(1 << 20, 1)));
		fill_src = ID_BITS'($urandom_range(ID_MAX, 1));
		fill_dst = ID_BITS'($urandom_range(ID_MAX, 1));
		push_cmd(CMD_RESTART, 0, 0, 0, 0);
		repeat (TABLE_DEPTH)
			push_cmd($urandom_range(1) ? CMD_ADD_NEURON : CMD_ADD_LINK, fill_src, fill_dst,
			         1'($urandom_range(1)), 1);
		push_cmd(CMD_ADD_LINK, fill_src, fill_dst, 0, 1);
		push_cmd(CMD_ADD_NEURON, fill_src, fill_dst, 1, 1);
		settle();
		hold_request = 400;
		push_cmd(CMD_LIST, fill_src, fill_dst, 1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat (5)
			push_cmd(CMD_LOOKUP, fill_src, fill_dst, 1'($urandom_range(1)),
			         1'($urandom_range(1)));
		settle();

		// counters start near the top so they wrap during the phase
		write_reg(REG_START_INNOVATION, ID_BITS'(ID_MAX - 20));
		write_reg(REG_START_NEURON, ID_BITS'(ID_MAX - 10));
		push_cmd(CMD_RESTART, 0, 0, 0, 0);
		random_phase(60);
		settle();

		write_reg(REG_START_INNOVATION, ID_BITS'($urandom_range(ID_MAX, 1)));
		write_reg(REG_START_NEURON, ID_BITS'($urandom_range(ID_MAX, 1)));
		push_cmd(CMD_RESTART, 0, 0, 0, 0);
		random_phase(60);
		settle();

		write_reg(REG_START_INNOVATION, 1);
		write_reg(REG_START_NEURON, 1);
		push_cmd(CMD_RESTART, 0, 0, 0, 0);
		random_phase(60);
		settle();

		repeat (20) @(negedge clk);
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
